/* src/keyframe_matrix_sampler_assert.svh */
// assertion macros used by the checker file
`ifndef KEYFRAME_MATRIX_SAMPLER_ASSERT_SVH
`define KEYFRAME_MATRIX_SAMPLER_ASSERT_SVH

// same-cycle implication
`define KMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/kms_pkg.sv */
// ----------------------------------------------------------------------------
// kms_pkg
// types, constants and helpers of the keyframe matrix sampler
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

	localparam int DEFAULT_MAX_KEYS = 64;
	localparam int ELEMS            = 12;
	localparam logic [3:0] ELEM_LAST = 4'd11;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	typedef enum logic [1:0] {
		OP_WR_FRAME = 2'd0,
		OP_WR_ELEM  = 2'd1,
		OP_SAMPLE   = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAST_CMP,
		S_SCAN0,
		S_SCAN_CMP,
		S_DIV,
		S_WCHK,
		S_EL_RDA,
		S_EL_RDB,
		S_EL_MUL,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		M_IDENT,
		M_KEY,
		M_BLEND
	} mode_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         key_slot;
		logic [15:0]        key_frame_number;
		logic [3:0]         element_slot;
		logic signed [31:0] element_value;
		logic signed [23:0] sample_frame;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         out_element_slot;
		logic signed [31:0] out_element_value;
		logic               last_element;
		logic               before_first_key;
	} out_item_t;

	function automatic logic signed [31:0] identity_elem(input logic [3:0] e);
		return (e == 4'd0 || e == 4'd4 || e == 4'd8) ? ONE_Q16 : 32'sd0;
	endfunction

endpackage

`default_nettype wire

/* src/kms_ram.sv */
// ----------------------------------------------------------------------------
// kms_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module kms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/keyframe_matrix_sampler.sv */
// ----------------------------------------------------------------------------
// keyframe_matrix_sampler
// 4x3 matrix key track with linear interpolation between keys
// ----------------------------------------------------------------------------
// usage:
//   cfg_we/cfg_wdata write key_count, only while the block is idle.
//   the input channel (in_valid/in_stall/in_data) takes one transaction at a
//   time: opcode 0 writes a key frame number, 1 a key matrix element, 2 asks
//   for a sample. writes finish in the cycle they are accepted.
//   a sample answers with twelve output transactions (out_valid/out_stall/
//   out_data), element order, last_element on the twelfth.
//   in_stall is high from a sample until its last element is in the output
//   register. an identity answer is emitted directly. a stored key, for a
//   single key or at or past the last key, is read from the matrix ram
//   element by element. a blend scans the key frames, one frame read each,
//   to find segment i, runs a 16 step restoring divide for the weight, then
//   reads both keys and multiplies; a zero weight gives the stored key i,
//   no segment gives the identity with before_first_key.
//   an output stall holds the result in the output register; the sequencer
//   waits in its emit state until it is taken.
//   reset clears key_count and the control state; key rams are undefined
//   until written.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_matrix_sampler
	import kms_pkg::*;
#(
	parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [6:0] cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	localparam int FAW = $clog2(MAX_KEYS);
	localparam int KW  = $clog2(MAX_KEYS + 1);
	localparam int MAW = $clog2(MAX_KEYS * ELEMS);

	// control registers
	state_t     state_q, state_d;
	logic [6:0] key_count_q;
	logic       out_valid_q;
	out_item_t  out_q;

	// datapath registers
	mode_t              mode_q;
	logic               flag_q;
	logic signed [23:0] f_q;
	logic [15:0]        lo_q;
	logic [FAW-1:0]     i_q;
	logic [FAW-1:0]     key_q;
	logic [23:0]        rem_q;
	logic [23:0]        div_q;
	logic [15:0]        w_q;
	logic [3:0]         cnt_q;
	logic [3:0]         e_q;
	logic signed [31:0] a_q;
	logic signed [49:0] prod_q;

	// ram ports
	logic           frame_we, frame_re;
	logic [FAW-1:0] frame_waddr, frame_raddr;
	logic [15:0]    frame_rdata;
	logic           mat_we, mat_re;
	logic [MAW-1:0] mat_waddr, mat_raddr;
	logic [31:0]    mat_rdata;

	// helpers
	logic [KW-1:0]      n_w;
	logic [FAW-1:0]     nm1_w;
	logic               in_acc;
	logic               slot_ok;
	logic               f_pos_in;
	logic [15:0]        f_int;
	logic               seg_hit;
	logic               scan_end;
	logic [24:0]        r2;
	logic               r_ge;
	logic               out_free;
	logic               out_load;
	logic [FAW-1:0]     key_b;
	logic signed [32:0] diff;
	logic signed [49:0] rnd;
	logic signed [31:0] emit_val;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign slot_ok  = (32'(in_data.key_slot) < MAX_KEYS);
	assign f_pos_in = !in_data.sample_frame[23] && (in_data.sample_frame != 24'sd0);

	// key count saturates at the track depth
	assign n_w   = (32'(key_count_q) > MAX_KEYS) ? KW'(MAX_KEYS) : KW'(key_count_q);
	assign nm1_w = FAW'(n_w - KW'(1));

	// frame comparisons on the integer part, frame is known positive here
	assign f_int    = 16'(f_q[23:8]);
	assign seg_hit  = (lo_q <= f_int) && (f_int < frame_rdata);
	assign scan_end = (FAW'(i_q + FAW'(1)) == nm1_w);

	// one restoring divide step
	assign r2   = {rem_q, 1'b0};
	assign r_ge = (r2 >= {1'b0, div_q});

	assign key_b    = FAW'(key_q + FAW'(1));
	assign diff     = 33'(signed'(mat_rdata)) - 33'(a_q);
	assign rnd      = prod_q + 50'sd32768;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		unique case (mode_q)
			M_IDENT: emit_val = identity_elem(e_q);
			M_KEY:   emit_val = a_q;
			M_BLEND: emit_val = a_q + 32'(rnd >>> 16);
			default: emit_val = a_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_data.opcode == OP_SAMPLE) begin
					priority if (n_w == KW'(0) || !f_pos_in) state_d = S_EMIT;
					else if (n_w == KW'(1))                state_d = S_EL_RDA;
					else                                   state_d = S_LAST_CMP;
				end
			end
			S_LAST_CMP: state_d = (frame_rdata <= f_int) ? S_EL_RDA : S_SCAN0;
			S_SCAN0:    state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				priority if (seg_hit) state_d = S_DIV;
				else if (scan_end)    state_d = S_EMIT;
				else                  state_d = S_SCAN_CMP;
			end
			S_DIV:    if (cnt_q == 4'd15) state_d = S_WCHK;
			S_WCHK:   state_d = S_EL_RDA;
			S_EL_RDA: state_d = S_EL_RDB;
			S_EL_RDB: state_d = (mode_q == M_BLEND) ? S_EL_MUL : S_EMIT;
			S_EL_MUL: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					priority if (e_q == ELEM_LAST) state_d = S_IDLE;
					else if (mode_q == M_IDENT)    state_d = S_EMIT;
					else                           state_d = S_EL_RDA;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ram control and output load
	always_comb begin
		frame_we    = in_acc && in_data.opcode == OP_WR_FRAME && slot_ok;
		frame_waddr = FAW'(in_data.key_slot);
		mat_we      = in_acc && in_data.opcode == OP_WR_ELEM && slot_ok
		              && (in_data.element_slot <= ELEM_LAST);
		mat_waddr   = MAW'(in_data.key_slot) * MAW'(ELEMS) + MAW'(in_data.element_slot);
		frame_re    = 1'b0;
		frame_raddr = nm1_w;
		mat_re      = 1'b0;
		mat_raddr   = MAW'(key_q) * MAW'(ELEMS) + MAW'(e_q);
		out_load    = 1'b0;
		unique case (state_q)
			S_IDLE:     frame_re = in_acc && in_data.opcode == OP_SAMPLE;
			S_LAST_CMP: begin
				frame_re    = 1'b1;
				frame_raddr = FAW'(0);
			end
			S_SCAN0: begin
				frame_re    = 1'b1;
				frame_raddr = FAW'(1);
			end
			S_SCAN_CMP: begin
				frame_re    = !seg_hit && !scan_end;
				frame_raddr = FAW'(i_q + FAW'(2));
			end
			S_EL_RDA: mat_re = 1'b1;
			S_EL_RDB: begin
				mat_re    = (mode_q == M_BLEND);
				mat_raddr = MAW'(key_b) * MAW'(ELEMS) + MAW'(e_q);
			end
			S_EMIT:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				key_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.out_element_slot  <= e_q;
			out_q.out_element_value <= emit_val;
			out_q.last_element      <= (e_q == ELEM_LAST);
			out_q.before_first_key  <= flag_q;
		end
		unique case (state_q)
			S_IDLE: begin
				f_q    <= in_data.sample_frame;
				e_q    <= '0;
				flag_q <= 1'b0;
				key_q  <= '0;
				mode_q <= (n_w == KW'(0) || !f_pos_in) ? M_IDENT : M_KEY;
			end
			S_LAST_CMP: key_q <= nm1_w;
			S_SCAN0: begin
				lo_q <= frame_rdata;
				i_q  <= '0;
			end
			S_SCAN_CMP: begin
				priority if (seg_hit) begin
					key_q <= i_q;
					rem_q <= {16'(f_int - lo_q), f_q[7:0]};
					div_q <= {16'(frame_rdata - lo_q), 8'd0};
					cnt_q <= '0;
				end else if (scan_end) begin
					mode_q <= M_IDENT;
					flag_q <= 1'b1;
				end else begin
					lo_q <= frame_rdata;
					i_q  <= FAW'(i_q + FAW'(1));
				end
			end
			S_DIV: begin
				rem_q <= r_ge ? 24'(r2 - {1'b0, div_q}) : r2[23:0];
				w_q   <= {w_q[14:0], r_ge};
				cnt_q <= cnt_q + 4'd1;
			end
			S_WCHK:   mode_q <= (w_q == 16'd0) ? M_KEY : M_BLEND;
			S_EL_RDB: a_q <= signed'(mat_rdata);
			S_EL_MUL: prod_q <= 50'(diff) * 50'(signed'({1'b0, w_q}));
			S_EMIT: if (out_load) e_q <= e_q + 4'd1;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	kms_ram #(.WIDTH(16), .DEPTH(MAX_KEYS)) u_frames (
		.clk   (clk),
		.we    (frame_we),
		.waddr (frame_waddr),
		.wdata (in_data.key_frame_number),
		.re    (frame_re),
		.raddr (frame_raddr),
		.rdata (frame_rdata)
	);

	kms_ram #(.WIDTH(32), .DEPTH(MAX_KEYS * ELEMS)) u_matrices (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (in_data.element_value),
		.re    (mat_re),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

endmodule

`default_nettype wire

/* src/kms_checker.sv */
// ----------------------------------------------------------------------------
// kms_checker
// port level checks of the keyframe matrix sampler
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyframe_matrix_sampler_assert.svh"

module kms_checker
	import kms_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      cfg_we,
	input wire logic [6:0] cfg_wdata,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	logic id_ok;
	assign id_ok = (out_data.out_element_value == identity_elem(out_data.out_element_slot));

	// a stalled result stays
	`KMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// last flag marks the twelfth element only
	`KMS_ASSERT_IMPL(a_last, clk, arst_n, out_valid,
		out_data.last_element == (out_data.out_element_slot == ELEM_LAST))
	// a sample transaction makes the block busy
	`KMS_ASSERT_NEXT(a_busy, clk, arst_n,
		in_valid && !in_stall && in_data.opcode == OP_SAMPLE, in_stall)
	// fallback answer is the identity
	`KMS_ASSERT_IMPL(a_fallback, clk, arst_n, out_valid && out_data.before_first_key, id_ok)

endmodule

bind keyframe_matrix_sampler kms_checker u_kms_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keyframe matrix sampler: loads a key track,
// samples it with directed and random frames under random valid/stall
// idling, predicts every matrix element and compares each output transaction
// ----------------------------------------------------------------------------
`default_nettype none

// scoreboard: own copy of the key track and key_count, queue of predicted
// output elements
class sampler_scoreboard;
	logic [15:0] frames [kms_pkg::DEFAULT_MAX_KEYS];
	int          mats   [kms_pkg::DEFAULT_MAX_KEYS][kms_pkg::ELEMS];
	int unsigned key_count;
	kms_pkg::out_item_t pending_elems [$];
	int errors;
	int samples;
	int blends;
	int checked;

	function new();
		key_count = 0;
		errors    = 0;
		samples   = 0;
		blends    = 0;
		checked   = 0;
	endfunction

	function void push_matrix(input int vals [kms_pkg::ELEMS], input bit flag);
		kms_pkg::out_item_t o;
		for (int e = 0; e < kms_pkg::ELEMS; e++) begin
			o.out_element_slot  = e[3:0];
			o.out_element_value = vals[e];
			o.last_element      = (e == kms_pkg::ELEMS - 1);
			o.before_first_key  = flag;
			pending_elems.push_back(o);
		end
	endfunction

	function void push_unit(input bit flag);
		int v [kms_pkg::ELEMS];
		for (int e = 0; e < kms_pkg::ELEMS; e++)
			v[e] = (e == 0 || e == 4 || e == 8) ? 32'h0001_0000 : 0;
		push_matrix(v, flag);
	endfunction

	function void push_key(input int k);
		int v [kms_pkg::ELEMS];
		for (int e = 0; e < kms_pkg::ELEMS; e++)
			v[e] = mats[k][e];
		push_matrix(v, 1'b0);
	endfunction

	// expected answer to one sample transaction, f in signed Q16.8
	function void predict_sample(input int f);
		int n;
		longint lo, hi, w, a, b, d;
		int v [kms_pkg::ELEMS];
		samples++;
		n = (key_count > kms_pkg::DEFAULT_MAX_KEYS) ? kms_pkg::DEFAULT_MAX_KEYS : key_count;
		if (n == 0 || f <= 0) begin
			push_unit(1'b0);
			return;
		end
		if (n == 1) begin
			push_key(0);
			return;
		end
		if (int'(frames[n-1]) <= (f >>> 8)) begin
			push_key(n - 1);
			return;
		end
		for (int i = 0; i + 1 < n; i++) begin
			lo = longint'(frames[i]) * 256;
			hi = longint'(frames[i+1]) * 256;
			if (lo <= f && longint'(f) < hi) begin
				w = ((longint'(f) - lo) * 65536) / (hi - lo);
				if (w == 0) begin
					push_key(i);
					return;
				end
				// round to nearest, tie toward plus infinity
				for (int e = 0; e < kms_pkg::ELEMS; e++) begin
					a = mats[i][e];
					b = mats[i+1][e];
					d = ((b - a) * w + 32768) >>> 16;
					v[e] = int'(a + d);
				end
				blends++;
				push_matrix(v, 1'b0);
				return;
			end
		end
		// before the first key or track not ascending
		push_unit(1'b1);
	endfunction

	function void note_input(input kms_pkg::in_item_t it);
		case (it.opcode)
			kms_pkg::OP_WR_FRAME: begin
				frames[it.key_slot] = it.key_frame_number;
			end
			kms_pkg::OP_WR_ELEM: begin
				if (it.element_slot < kms_pkg::ELEMS)
					mats[it.key_slot][it.element_slot] = it.element_value;
			end
			kms_pkg::OP_SAMPLE: begin
				predict_sample(int'(it.sample_frame));
			end
			default: ;
		endcase
	endfunction

	function void check_elem(input kms_pkg::out_item_t got);
		kms_pkg::out_item_t want;
		if (pending_elems.size() == 0) begin
			errors++;
			$display("%0t: unexpected output transaction %h", $time, got);
			return;
		end
		want = pending_elems.pop_front();
		checked++;
		if (got.out_element_slot !== want.out_element_slot) begin
			errors++;
			$display("%0t: out_element_slot expected %0d actual %0d", $time,
				want.out_element_slot, got.out_element_slot);
		end
		if (got.out_element_value !== want.out_element_value) begin
			errors++;
			$display("%0t: out_element_value expected %h actual %h", $time,
				want.out_element_value, got.out_element_value);
		end
		if (got.last_element !== want.last_element) begin
			errors++;
			$display("%0t: last_element expected %b actual %b", $time,
				want.last_element, got.last_element);
		end
		if (got.before_first_key !== want.before_first_key) begin
			errors++;
			$display("%0t: before_first_key expected %b actual %b", $time,
				want.before_first_key, got.before_first_key);
		end
	endfunction
endclass

module tb_top;
	import kms_pkg::*;

	// keys 0..TRACK_KEYS-1 carry the loaded tracks, key TRACK_KEYS is the
	// upper neighbor of the last segment, all further keys keep the top frame
	localparam int TRACK_KEYS = 12;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [6:0] cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	// idle percentages of sender and receiver, changed per phase
	int send_idle;
	int recv_stall;
	int items_sent;
	int count_writes;

	sampler_scoreboard sb;

	keyframe_matrix_sampler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit, far above the slowest legal run
	initial begin
		#60000000;
		$display("keyframe_matrix_sampler: mismatch");
		$finish;
	end

	// receiver stall, random per cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	// monitor: signals read here are the values before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(in_data);
			if (out_valid && !out_stall)
				sb.check_elem(out_data);
		end
	end

	function automatic in_item_t make_item(input opcode_t op, input int slot, input int fnum,
			input int el, input int val, input int sf);
		in_item_t it;
		it.opcode           = op;
		it.key_slot         = slot[5:0];
		it.key_frame_number = fnum[15:0];
		it.element_slot     = el[3:0];
		it.element_value    = val;
		it.sample_frame     = sf[23:0];
		return it;
	endfunction

	// one input transaction; valid is only lowered while idling
	task automatic send(input in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			in_data  <= make_item(opcode_t'($urandom_range(3)), $urandom, $urandom,
				$urandom, $urandom, $urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	// wait until every predicted element has come out and the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_elems.size() != 0 || in_stall)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_count(input int n);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= n[6:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.key_count = n;
		count_writes++;
		@(posedge clk);
	endtask

	task automatic put_frame(input int k, input int fnum);
		send(make_item(OP_WR_FRAME, k, fnum, 0, 0, 0));
	endtask

	task automatic put_elem(input int k, input int e, input int val);
		send(make_item(OP_WR_ELEM, k, 0, e, val, 0));
	endtask

	task automatic ask(input int sf);
		send(make_item(OP_SAMPLE, 0, 0, 0, 0, sf));
	endtask

	// rewrite keys 0..n-1 with ascending frames, now and then a broken order
	task automatic load_track(input int n);
		int fr;
		fr = $urandom_range(40);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(19) == 0)
				put_frame(k, $urandom_range(60));
			else
				put_frame(k, fr);
			fr += $urandom_range(1, 12);
			if ($urandom_range(2) == 0)
				put_elem(k, $urandom_range(ELEMS - 1), $urandom);
		end
	endtask

	// one random phase of about cnt counted transactions
	task automatic random_phase(input int cnt);
		int start;
		int n;
		int nl;
		int top;
		int pick;
		start = items_sent;
		while (items_sent - start < cnt) begin
			pick = $urandom_range(9);
			if (pick < 6)
				n = $urandom_range(2, 8);
			else if (pick == 6)
				n = $urandom_range(1);
			else if (pick == 7)
				n = $urandom_range(9, TRACK_KEYS);
			else
				n = $urandom_range(65, 127);
			// above the key limit the keys past the track keep the top frame
			nl = (n > DEFAULT_MAX_KEYS) ? TRACK_KEYS : n;
			set_count(n);
			load_track(nl);
			top = (nl == 0) ? 10 : int'(sb.frames[nl-1]) + 2;
			repeat ($urandom_range(6, 14)) begin
				pick = $urandom_range(19);
				if (pick < 15)
					ask($urandom_range(top * 256 + 256) - 256);
				else if (pick == 15)
					ask($urandom);
				else if (pick == 16)
					put_elem($urandom_range(63), $urandom_range(ELEMS - 1), $urandom);
				else if (pick == 17)
					put_frame($urandom_range(nl, 63), 65535);
				else if (pick == 18) begin
					// ignored element slot, not counted
					put_elem($urandom_range(63), $urandom_range(12, 15), $urandom);
					items_sent--;
				end else begin
					// unused opcode, not counted
					send(make_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
					items_sent--;
				end
			end
			// now and then the sender holds off until the whole answer backlog is out
			if ($urandom_range(3) == 0)
				drain();
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		items_sent = 0;
		count_writes = 0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no keys: identity, no flag
		ask(256);
		ask(-8388608);

		// every frame written, matrices on the keys a sample can reach
		for (int k = 0; k < DEFAULT_MAX_KEYS; k++) begin
			put_frame(k, (k < TRACK_KEYS) ? 10 + 4 * k : 65535);
			if (k <= TRACK_KEYS)
				for (int e = 0; e < ELEMS; e++)
					put_elem(k, e, $urandom);
		end
		// extreme elements on keys 0 and 1
		put_elem(0, 0, 32'h8000_0000);
		put_elem(1, 0, 32'h7fff_ffff);
		put_elem(0, 1, 32'h7fff_ffff);
		put_elem(1, 1, 32'h8000_0000);
		put_elem(0, 15, 32'hffff_ffff);  // ignored slot
		send(make_item(OP_NONE, 63, 65535, 15, -1, -1));

		set_count(1);
		ask(8388607);                       // single key
		set_count(3);
		ask(0);                             // frame not positive
		ask(-1);
		ask(9 * 256 + 255);                 // before the first key
		ask(10 * 256);                      // exactly on key 0, zero weight
		ask(10 * 256 + 1);                  // smallest weight
		ask(11 * 256 + 128);                // blend with extremes
		ask(17 * 256 + 255);
		ask(18 * 256);                      // at the last key
		ask(8388607);                       // far past the last key
		set_count(64);
		ask(200 * 256 + 77);
		set_count(127);                     // above the key limit
		ask(100 * 256 + 3);
		put_frame(1, 65535);                // track no longer ascending
		set_count(3);
		ask(30 * 256);
		put_frame(2, 0);
		ask(15 * 256);
		set_count(0);
		ask(8388607);

		send_idle = 27;
		recv_stall = 78;
		random_phase(60);
		send_idle = 78;
		recv_stall = 27;
		random_phase(60);
		send_idle = 0;
		recv_stall = 0;
		random_phase(61);

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d samples (%0d blends), %0d elements checked, %0d key_count writes",
			sb.samples, sb.blends, sb.checked, count_writes);
		$display("idling: sender 27/receiver 78, sender 78/receiver 27, none");
		if (sb.errors == 0 && sb.pending_elems.size() == 0)
			$display("keyframe_matrix_sampler: match");
		else
			$display("keyframe_matrix_sampler: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

/* keyframe_matrix_sampler.f */
+incdir+src
src/kms_pkg.sv
src/kms_ram.sv
src/keyframe_matrix_sampler.sv
src/kms_checker.sv
tb/sv/tb_top.sv
